// ===== rtl/core/tgi_pkg.sv =====
// Shared types and constants for the trilinear grid interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package tgi_pkg;

    // Grid size along each axis.
    localparam int SIZE_X = 32;
    localparam int SIZE_Y = 32;
    localparam int SIZE_Z = 32;

    // Cell index and fraction widths.
    localparam int IDX_W  = 5;
    localparam int FRAC_W = 16;
    localparam int POS_W  = IDX_W + FRAC_W;

    // Parity banks: each bank holds every second cell along each axis.
    localparam int BANK_N  = 8;
    localparam int BANK_AW = 3 * (IDX_W - 1);
    localparam int BANK_D  = 1 << BANK_AW;

    // Queue between front and back.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;
    localparam int Q_CW    = 4;

    // Clamp limits, (SIZE - 2) in unsigned Q5.16.
    localparam logic [POS_W-1:0] LIM_X = POS_W'((SIZE_X - 2) << FRAC_W);
    localparam logic [POS_W-1:0] LIM_Y = POS_W'((SIZE_Y - 2) << FRAC_W);
    localparam logic [POS_W-1:0] LIM_Z = POS_W'((SIZE_Z - 2) << FRAC_W);

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_INV_STEP_X = 3'd3,
        REG_INV_STEP_Y = 3'd4,
        REG_INV_STEP_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [31:0]        inv_step_x;
        logic [31:0]        inv_step_y;
        logic [31:0]        inv_step_z;
    } cfg_t;

    // One classified item as it travels from front to back.
    typedef struct packed {
        func_t             func;
        logic [IDX_W-1:0]  cell_y;
        logic [IDX_W-1:0]  cell_x;
        logic [IDX_W-1:0]  cell_z;
        logic [15:0]       cell_value;
        logic [IDX_W-1:0]  jy;
        logic [IDX_W-1:0]  jx;
        logic [IDX_W-1:0]  jz;
        logic [FRAC_W-1:0] fy;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fz;
    } q_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/trilinear_grid_interpolator.sv =====
// Trilinear grid interpolator, top level.
// Uses tgi_pkg, tgi_cfg_regs, tgi_front, tgi_queue and tgi_back.
//
// Usage:
//   The input stream carries one item per transfer. s_tuser selects the
//   kind: a write stores cell_value at (cell_y, cell_x, cell_z); a query
//   carries a Q16.16 point and yields one 16-bit result on the m_ stream.
//   Writes yield nothing. Writes and queries take effect in stream order.
//   The APB port sets the three origins and reciprocal spacings; write it
//   only while no item is in flight.
//   Throughput is one item per cycle while s_tready is high. A query
//   passes through three front stages (difference, products, clamp), the
//   queue, then the bank read, three blend stages and the output register.
//   All eight corners come from eight parity banks read in the same cycle.
//   When a result waits and m_tready is low the back pipeline holds; the
//   front keeps taking items into the 8-entry queue and s_tready drops once
//   the queue and the front stages together hold eight items.
//   Reset (aresetn low, synchronous) empties the pipeline and the queue
//   and restores the registers. Cube samples are not cleared: a query must
//   only touch cells that were written.
`default_nettype none
module trilinear_grid_interpolator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata, low bit up: cell_y[4:0], cell_x[9:5], cell_z[14:10],
    // cell_value[30:15], query_x[62:31], query_y[94:63], query_z[126:95], zero pad
    input  wire logic [127:0] s_tdata,
    // s_tuser: func (0 write, 1 query)
    input  wire logic         s_tuser,
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata: interp_value[15:0]
    output logic [15:0]       m_tdata,
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tgi_pkg::*;

    cfg_t       cfg;
    logic       s_acc;
    logic       f_valid;
    q_entry_t   f_entry;
    logic [1:0] f_busy;
    q_entry_t   q_dout;
    logic       q_nonempty;
    logic [3:0] q_count;
    logic       q_pop;
    logic [4:0] occupancy;

    // Credit: items in the front stages always find room in the queue.
    assign occupancy = {1'b0, q_count} + 5'(f_busy);
    assign s_tready  = (occupancy < 5'(Q_DEPTH));
    assign s_acc     = s_tvalid && s_tready;

    tgi_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_acc),
        .in_func       (func_t'(s_tuser)),
        .in_cell_y     (s_tdata[4:0]),
        .in_cell_x     (s_tdata[9:5]),
        .in_cell_z     (s_tdata[14:10]),
        .in_cell_value (s_tdata[30:15]),
        .in_query_x    (s_tdata[62:31]),
        .in_query_y    (s_tdata[94:63]),
        .in_query_z    (s_tdata[126:95]),
        .cfg           (cfg),
        .out_valid     (f_valid),
        .out_entry     (f_entry),
        .busy          (f_busy)
    );

    tgi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (f_valid),
        .din      (f_entry),
        .pop      (q_pop),
        .dout     (q_dout),
        .nonempty (q_nonempty),
        .count    (q_count)
    );

    tgi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_nonempty),
        .in_entry (q_dout),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The queue and the front stages never hold more items than the queue has room for.
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= 5'(Q_DEPTH))
        else $error("front and queue hold more items than the queue depth");

    // A push into a full queue must be matched by a pop in the same cycle.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && q_count == 4'(Q_DEPTH)) |-> q_pop)
        else $error("queue overflow");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_nonempty)
        else $error("queue underflow");

endmodule
`default_nettype wire

// ===== rtl/core/tgi_cfg_regs.sv =====
// Configuration register file with an APB-style port.
// Depends on tgi_pkg for the register indexes and the config struct.
`default_nettype none
module tgi_cfg_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tgi_pkg::cfg_t     cfg
);
    import tgi_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    // Register writes on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.origin_z   <= '0;
            cfg_reg.inv_step_x <= 32'h0001_0000;
            cfg_reg.inv_step_y <= 32'h0001_0000;
            cfg_reg.inv_step_z <= 32'h0001_0000;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_ORIGIN_X:   cfg_reg.origin_x   <= pwdata;
                REG_ORIGIN_Y:   cfg_reg.origin_y   <= pwdata;
                REG_ORIGIN_Z:   cfg_reg.origin_z   <= pwdata;
                REG_INV_STEP_X: cfg_reg.inv_step_x <= pwdata;
                REG_INV_STEP_Y: cfg_reg.inv_step_y <= pwdata;
                REG_INV_STEP_Z: cfg_reg.inv_step_z <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (idx)
            REG_ORIGIN_X:   prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y:   prdata = cfg_reg.origin_y;
            REG_ORIGIN_Z:   prdata = cfg_reg.origin_z;
            REG_INV_STEP_X: prdata = cfg_reg.inv_step_x;
            REG_INV_STEP_Y: prdata = cfg_reg.inv_step_y;
            REG_INV_STEP_Z: prdata = cfg_reg.inv_step_z;
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/tgi_front.sv =====
// Front end: takes items and turns query points into cell index and fraction.
// Three stages (difference, products, sum and clamp). Depends on tgi_pkg.
`default_nettype none
module tgi_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire tgi_pkg::func_t     in_func,
    input  wire logic [4:0]         in_cell_y,
    input  wire logic [4:0]         in_cell_x,
    input  wire logic [4:0]         in_cell_z,
    input  wire logic [15:0]        in_cell_value,
    input  wire logic signed [31:0] in_query_x,
    input  wire logic signed [31:0] in_query_y,
    input  wire logic signed [31:0] in_query_z,
    input  wire tgi_pkg::cfg_t      cfg,
    output logic                    out_valid,
    output tgi_pkg::q_entry_t       out_entry,
    output logic [1:0]              busy
);
    import tgi_pkg::*;

    logic              v0_reg, v1_reg, v2_reg;
    q_entry_t          e0_reg, e1_reg, e2_reg;
    q_entry_t          e0_next, e2_next;
    logic [31:0]       q_in  [3];
    logic [31:0]       org   [3];
    logic [31:0]       inv   [3];
    logic [POS_W-1:0]  lim   [3];
    logic [32:0]       diff  [3];
    logic [31:0]       ud_reg   [3];
    logic [31:0]       ud_next  [3];
    logic [47:0]       phi_reg  [3];
    logic [47:0]       plo_reg  [3];
    logic [47:0]       phi_next [3];
    logic [47:0]       plo_next [3];
    logic [48:0]       r_sum    [3];
    logic [POS_W-1:0]  pos      [3];

    assign out_valid = v2_reg;
    assign out_entry = e2_reg;
    assign busy      = 2'(v0_reg) + 2'(v1_reg) + 2'(v2_reg);

    // Axis order is x, y, z in the lane arrays.
    always_comb begin
        q_in[0] = in_query_x;     q_in[1] = in_query_y;     q_in[2] = in_query_z;
        org[0]  = cfg.origin_x;   org[1]  = cfg.origin_y;   org[2]  = cfg.origin_z;
        inv[0]  = cfg.inv_step_x; inv[1]  = cfg.inv_step_y; inv[2]  = cfg.inv_step_z;
        lim[0]  = LIM_X;          lim[1]  = LIM_Y;          lim[2]  = LIM_Z;
    end

    // Stage 0: exact difference; points at or below the origin give zero.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k]    = {q_in[k][31], q_in[k]} - {org[k][31], org[k]};
            ud_next[k] = (!diff[k][32] && (diff[k] != 33'd0)) ? diff[k][31:0] : 32'd0;
        end
        e0_next            = '0;
        e0_next.func       = in_func;
        e0_next.cell_y     = in_cell_y;
        e0_next.cell_x     = in_cell_x;
        e0_next.cell_z     = in_cell_z;
        e0_next.cell_value = in_cell_value;
    end

    // Stage 1: split product against the two halves of the reciprocal.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            phi_next[k] = 48'(ud_reg[k]) * 48'(inv[k][31:16]);
            plo_next[k] = 48'(ud_reg[k]) * 48'(inv[k][15:0]);
        end
    end

    // Stage 2: recombine, clamp to the last cell pair, split index and fraction.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_sum[k] = 49'(phi_reg[k]) + 49'(plo_reg[k][47:16]);
            pos[k]   = (r_sum[k] > 49'(lim[k])) ? lim[k] : r_sum[k][POS_W-1:0];
        end
        e2_next    = e1_reg;
        e2_next.jx = pos[0][POS_W-1:FRAC_W];
        e2_next.fx = pos[0][FRAC_W-1:0];
        e2_next.jy = pos[1][POS_W-1:FRAC_W];
        e2_next.fy = pos[1][FRAC_W-1:0];
        e2_next.jz = pos[2][POS_W-1:FRAC_W];
        e2_next.fz = pos[2][FRAC_W-1:0];
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e0_reg;
        e2_reg <= e2_next;
        for (int k = 0; k < 3; k++) begin
            ud_reg[k]  <= ud_next[k];
            phi_reg[k] <= phi_next[k];
            plo_reg[k] <= plo_next[k];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tgi_queue.sv =====
// Short FIFO of classified items between the front and the back.
// Depends on tgi_pkg for the entry type and depth.
`default_nettype none
module tgi_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire tgi_pkg::q_entry_t din,
    input  wire logic              pop,
    output tgi_pkg::q_entry_t      dout,
    output logic                   nonempty,
    output logic [3:0]             count
);
    import tgi_pkg::*;

    q_entry_t         mem [Q_DEPTH];
    logic [Q_AW-1:0]  wptr_reg, rptr_reg;
    logic [Q_CW-1:0]  count_reg;

    assign dout     = mem[rptr_reg];
    assign nonempty = (count_reg != '0);
    assign count    = count_reg;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + Q_CW'(push) - Q_CW'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) mem[wptr_reg] <= din;
    end

endmodule
`default_nettype wire

// ===== rtl/core/tgi_back.sv =====
// Back end: eight parity banks of the sample cube and the blend pipeline.
// Writes and reads happen in item order at the bank stage. Depends on tgi_pkg.
`default_nettype none
module tgi_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire tgi_pkg::q_entry_t in_entry,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata
);
    import tgi_pkg::*;

    logic              adv;
    logic [2:0]        wbank;
    logic [BANK_AW-1:0] waddr;
    logic [BANK_AW-1:0] raddr [BANK_N];
    logic [15:0]       rd_reg [BANK_N];

    logic              v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic [2:0]        par1_reg;
    logic [FRAC_W-1:0] fy1_reg, fx1_reg, fz1_reg, fy2_reg, fx2_reg, fy3_reg;
    logic [15:0]       s [BANK_N];
    logic [16:0]       wz, wx, wy;
    logic [31:0]       a_next [4];
    logic [31:0]       a_reg  [4];
    logic [47:0]       b_next [2];
    logic [47:0]       b_reg  [2];
    logic [47:0]       chi_next, chi_reg;
    logic [31:0]       clo_next, clo_reg;
    logic [63:0]       c_sum;
    logic [15:0]       out_reg;

    // The whole back pipeline moves when the output register can take an item.
    assign adv      = !out_v_reg || m_tready;
    assign pop      = adv && in_valid;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    // Bank addresses: each bank serves the corner whose coordinates match its parity.
    always_comb begin
        logic [IDX_W-1:0] yc, xc, zc;
        wbank = {in_entry.cell_y[0], in_entry.cell_x[0], in_entry.cell_z[0]};
        waddr = {in_entry.cell_y[IDX_W-1:1], in_entry.cell_x[IDX_W-1:1],
                 in_entry.cell_z[IDX_W-1:1]};
        for (int b = 0; b < BANK_N; b++) begin
            yc = in_entry.jy + IDX_W'(b[2] ^ in_entry.jy[0]);
            xc = in_entry.jx + IDX_W'(b[1] ^ in_entry.jx[0]);
            zc = in_entry.jz + IDX_W'(b[0] ^ in_entry.jz[0]);
            raddr[b] = {yc[IDX_W-1:1], xc[IDX_W-1:1], zc[IDX_W-1:1]};
        end
    end

    // Sample banks with registered read data.
    for (genvar g = 0; g < BANK_N; g++) begin : g_bank
        logic [15:0] mem [BANK_D];
        always_ff @(posedge aclk) begin
            if (pop) begin
                if (in_entry.func == FUNC_WRITE && wbank == 3'(g)) begin
                    mem[waddr] <= in_entry.cell_value;
                end
                if (in_entry.func == FUNC_QUERY) begin
                    rd_reg[g] <= mem[raddr[g]];
                end
            end
        end
    end

    // Blend along z for the four (y, x) corner columns.
    always_comb begin
        logic [2:0]  cor;
        logic [32:0] t;
        for (int c = 0; c < BANK_N; c++) begin
            cor  = 3'(c) ^ par1_reg;
            s[c] = rd_reg[cor];
        end
        wz = 17'h10000 - {1'b0, fz1_reg};
        for (int i = 0; i < 4; i++) begin
            t = 33'(s[2*i]) * 33'(wz) + 33'(s[2*i+1]) * 33'(fz1_reg);
            a_next[i] = t[31:0];
        end
    end

    // Blend along x.
    always_comb begin
        logic [48:0] t;
        wx = 17'h10000 - {1'b0, fx2_reg};
        for (int j = 0; j < 2; j++) begin
            t = 49'(a_reg[2*j]) * 49'(wx) + 49'(a_reg[2*j+1]) * 49'(fx2_reg);
            b_next[j] = t[47:0];
        end
    end

    // Blend along y, split into upper and lower partial sums.
    always_comb begin
        logic [48:0] th;
        logic [32:0] tl;
        wy = 17'h10000 - {1'b0, fy3_reg};
        th = 49'(b_reg[0][47:16]) * 49'(wy) + 49'(b_reg[1][47:16]) * 49'(fy3_reg);
        tl = 33'(b_reg[0][15:0]) * 33'(wy) + 33'(b_reg[1][15:0]) * 33'(fy3_reg);
        chi_next = th[47:0];
        clo_next = tl[31:0];
    end

    // Recombine and round half up to 16 bits.
    assign c_sum = {chi_reg, 16'h0000} + 64'(clo_reg) + 64'h0000_8000_0000_0000;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= pop && (in_entry.func == FUNC_QUERY);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            out_v_reg <= v4_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            par1_reg <= {in_entry.jy[0], in_entry.jx[0], in_entry.jz[0]};
            fy1_reg  <= in_entry.fy;
            fx1_reg  <= in_entry.fx;
            fz1_reg  <= in_entry.fz;
            fy2_reg  <= fy1_reg;
            fx2_reg  <= fx1_reg;
            fy3_reg  <= fy2_reg;
            for (int i = 0; i < 4; i++) a_reg[i] <= a_next[i];
            for (int j = 0; j < 2; j++) b_reg[j] <= b_next[j];
            chi_reg  <= chi_next;
            clo_reg  <= clo_next;
            out_reg  <= c_sum[63:48];
        end
    end

endmodule
`default_nettype wire
